FILE: rtl/scan_to_global_points_top_assert.svh
// Assertion macros shared by the scan-to-global-points RTL.
// Expects signals named clk and rst_n in the scope of each use.
`ifndef SCAN_TO_GLOBAL_POINTS_TOP_ASSERT_SVH
`define SCAN_TO_GLOBAL_POINTS_TOP_ASSERT_SVH

// Same-cycle implication, switched off while reset is held
`define STGP_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, switched off while reset is held
`define STGP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/stgp_pkg.sv
// Package for the scan-to-global-points block: transaction structs, widths,
// microcode field encodings and the microcode program. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package stgp_pkg;

  // Fixed widths
  localparam int COORD_BITS     = 24;
  localparam int TRIG_BITS      = 16;
  localparam int RANGE_BITS     = 16;
  localparam int CNT_BITS       = 10;
  localparam int TRIG_FRAC_BITS = 14;
  // local point: |range*trig| >> 14 stays within +-3000
  localparam int LOC_W          = 13;
  // multiplier B operand: kept range (< 1500) or a local coordinate
  localparam int MB_W           = 13;
  localparam int PROD_W         = TRIG_BITS + MB_W;
  // sum of two rotation products stays below 2^28
  localparam int ACC_W          = PROD_W;
  localparam int HALF_W         = ACC_W - TRIG_FRAC_BITS;
  localparam int STEP_W         = 3;

  localparam logic [RANGE_BITS-1:0] RANGE_CEILING = 16'd1500;
  localparam logic [RANGE_BITS-1:0] MIN_RANGE_RST = 16'd0;
  localparam logic [RANGE_BITS-1:0] MAX_RANGE_RST = 16'd1500;

  // Register index, taken from paddr[2]
  localparam logic REG_MIN_RANGE = 1'b0;
  localparam logic REG_MAX_RANGE = 1'b1;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [TRIG_BITS-1:0]  trig_t;

  localparam coord_t COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam coord_t COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

  typedef struct packed {
    logic [RANGE_BITS-1:0] beam_range;
    trig_t                 beam_cos;
    trig_t                 beam_sin;
    trig_t                 head_cos;
    trig_t                 head_sin;
    coord_t                pose_x;
    coord_t                pose_y;
    logic                  scan_start;
  } in_t;

  typedef struct packed {
    coord_t                point_x;
    coord_t                point_y;
    logic [CNT_BITS-1:0]   point_number;
    coord_t                box_min_x;
    coord_t                box_max_x;
    coord_t                box_min_y;
    coord_t                box_max_y;
  } out_t;

  // Multiplier operand pair
  typedef enum logic [2:0] {
    MS_RNG_BC,
    MS_RNG_BS,
    MS_HC_LX,
    MS_HS_LY,
    MS_HS_LX,
    MS_HC_LY
  } mul_sel_t;

  // What happens to last cycle's product
  typedef enum logic [2:0] {
    PO_NONE,
    PO_LX,
    PO_LY,
    PO_LOAD,
    PO_ADD,
    PO_SUB
  } prod_op_t;

  // Finishing a global coordinate from the accumulator
  typedef enum logic [1:0] {
    FN_NONE,
    FN_GX,
    FN_GY
  } fin_t;

  typedef struct packed {
    mul_sel_t msel;
    prod_op_t pop;
    fin_t     fin;
    logic     jmp_drop;  // leave the program if the beam is rejected
    logic     last;      // final step: emit the transaction
  } ucw_t;

  // Microcode program, one control word per step
  function automatic ucw_t ucode(input logic [STEP_W-1:0] step);
    ucw_t w;
    w = '{msel: MS_RNG_BC, pop: PO_NONE, fin: FN_NONE, jmp_drop: 1'b0, last: 1'b0};
    unique case (step)
      3'd0: begin
        w.msel     = MS_RNG_BC;
        w.jmp_drop = 1'b1;
      end
      3'd1: begin
        w.msel = MS_RNG_BS;
        w.pop  = PO_LX;
      end
      3'd2: begin
        w.msel = MS_HC_LX;
        w.pop  = PO_LY;
      end
      3'd3: begin
        w.msel = MS_HS_LY;
        w.pop  = PO_LOAD;
      end
      3'd4: begin
        w.msel = MS_HS_LX;
        w.pop  = PO_SUB;
      end
      3'd5: begin
        w.msel = MS_HC_LY;
        w.pop  = PO_LOAD;
        w.fin  = FN_GX;
      end
      3'd6: begin
        w.pop = PO_ADD;
      end
      3'd7: begin
        w.fin  = FN_GY;
        w.last = 1'b1;
      end
    endcase
    return w;
  endfunction

  // Clamp a one-bit-wider sum to the coordinate range
  function automatic coord_t sat_coord(input logic signed [COORD_BITS:0] v);
    coord_t r;
    if (v[COORD_BITS] != v[COORD_BITS-1]) begin
      r = v[COORD_BITS] ? COORD_MIN : COORD_MAX;
    end else begin
      r = v[COORD_BITS-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/scan_to_global_points_top.sv
// Top level of the scan-to-global-points block: microcoded sequencer driving
// one shared multiplier, APB register file and the result register.
// Depends on stgp_pkg and scan_to_global_points_top_assert.svh.
//
// Usage:
//  - Input channel (in_valid/in_ready/in_data): one laser beam per
//    transaction with its range, bearing cos/sin, heading cos/sin and pose.
//  - Output channel (out_valid/out_ready/out_data): one transaction per kept
//    beam: global point, its number within the scan and the bounding box.
//  - APB port: min_range at 0x0, max_range at 0x4; write only while idle.
//  - in_ready is high while the sequencer is idle. A kept beam runs an
//    eight-step program on one 16x13 multiplier (one product per step), so
//    the next beam is taken only after the program ends and its result is
//    registered. A rejected beam leaves after the first step, with no result.
//  - The result sits in an output register; if the receiver stalls, the
//    final step waits until that register is free, and input stays blocked.
//  - Reset sets min_range 0, max_range 1500, an empty bounding box and the
//    point number to zero. scan_start clears the point number on acceptance.
`timescale 1ns / 1ps
`default_nettype none

`include "scan_to_global_points_top_assert.svh"

module scan_to_global_points_top
  import stgp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire in_t         in_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output out_t             out_data,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  // Registers
  logic                    busy_r;
  logic [STEP_W-1:0]       step_r;
  logic [RANGE_BITS-1:0]   min_range_r;
  logic [RANGE_BITS-1:0]   max_range_r;
  logic [CNT_BITS-1:0]     cnt_r;
  coord_t                  lowest_x_r;
  coord_t                  highest_x_r;
  coord_t                  lowest_y_r;
  coord_t                  highest_y_r;
  logic                    out_valid_r;
  out_t                    out_r;
  in_t                     in_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [LOC_W-1:0]  lx_r;
  logic signed [LOC_W-1:0]  ly_r;
  coord_t                  gx_r;

  // Combinational
  ucw_t                     ucw;
  logic                     in_fire;
  logic                     cfg_wr;
  logic                     drop_w;
  logic                     hold_w;
  logic                     emit_w;
  trig_t                    op_a;
  logic signed [MB_W-1:0]   op_b;
  logic signed [PROD_W-1:0] prod_nxt;
  logic signed [ACC_W-1:0]  acc_nxt;
  coord_t                   pose_sel;
  logic signed [COORD_BITS:0] gsum_w;
  coord_t                   gsat_w;
  coord_t                   low_y_nxt;
  coord_t                   high_y_nxt;
  logic                     in_box_w;

  assign ucw      = ucode(step_r);
  assign in_ready = !busy_r;
  assign in_fire  = in_valid && in_ready;
  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite && pready;

  // Register reads
  always_comb begin
    prdata = '0;
    unique case (paddr[2])
      REG_MIN_RANGE: prdata[RANGE_BITS-1:0] = min_range_r;
      REG_MAX_RANGE: prdata[RANGE_BITS-1:0] = max_range_r;
    endcase
  end

  // Range gate, judged in the first step
  assign drop_w = (in_r.beam_range >= max_range_r) || (in_r.beam_range <= min_range_r) ||
                  (in_r.beam_range >= RANGE_CEILING);

  // Final step waits while the output register is still occupied
  assign hold_w = ucw.last && out_valid_r && !out_ready;
  assign emit_w = busy_r && ucw.last && !hold_w;

  // Shared multiplier operand selection
  always_comb begin
    unique case (ucw.msel)
      MS_RNG_BC: begin
        op_a = in_r.beam_cos;
        op_b = $signed({1'b0, in_r.beam_range[MB_W-2:0]});
      end
      MS_RNG_BS: begin
        op_a = in_r.beam_sin;
        op_b = $signed({1'b0, in_r.beam_range[MB_W-2:0]});
      end
      MS_HC_LX: begin
        op_a = in_r.head_cos;
        op_b = lx_r;
      end
      MS_HS_LY: begin
        op_a = in_r.head_sin;
        op_b = ly_r;
      end
      MS_HS_LX: begin
        op_a = in_r.head_sin;
        op_b = lx_r;
      end
      MS_HC_LY: begin
        op_a = in_r.head_cos;
        op_b = ly_r;
      end
      default: begin
        op_a = in_r.beam_cos;
        op_b = lx_r;
      end
    endcase
  end

  assign prod_nxt = op_a * op_b;

  // Accumulator update from last step's product
  always_comb begin
    unique case (ucw.pop)
      PO_LOAD: acc_nxt = prod_r;
      PO_ADD:  acc_nxt = acc_r + prod_r;
      PO_SUB:  acc_nxt = acc_r - prod_r;
      default: acc_nxt = acc_r;
    endcase
  end

  // Global coordinate: floor shift, pose offset, saturation
  assign pose_sel = (ucw.fin == FN_GY) ? in_r.pose_y : in_r.pose_x;
  assign gsum_w   = {{(COORD_BITS+1-HALF_W){acc_r[ACC_W-1]}}, acc_r[ACC_W-1:TRIG_FRAC_BITS]} +
                    {pose_sel[COORD_BITS-1], pose_sel};
  assign gsat_w   = sat_coord(gsum_w);

  assign low_y_nxt  = (gsat_w < lowest_y_r)  ? gsat_w : lowest_y_r;
  assign high_y_nxt = (gsat_w > highest_y_r) ? gsat_w : highest_y_r;

  // Datapath registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      in_r <= in_data;
    end
    if (busy_r) begin
      prod_r <= prod_nxt;
      acc_r  <= acc_nxt;
      if (ucw.pop == PO_LX) begin
        lx_r <= prod_r[LOC_W+TRIG_FRAC_BITS-1:TRIG_FRAC_BITS];
      end
      if (ucw.pop == PO_LY) begin
        ly_r <= prod_r[LOC_W+TRIG_FRAC_BITS-1:TRIG_FRAC_BITS];
      end
      if (ucw.fin == FN_GX) begin
        gx_r <= gsat_w;
      end
    end
    if (emit_w) begin
      out_r.point_x      <= gx_r;
      out_r.point_y      <= gsat_w;
      out_r.point_number <= cnt_r;
      out_r.box_min_x    <= lowest_x_r;
      out_r.box_max_x    <= highest_x_r;
      out_r.box_min_y    <= low_y_nxt;
      out_r.box_max_y    <= high_y_nxt;
    end
  end

  // Sequencer, configuration, box and counter state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      step_r      <= '0;
      min_range_r <= MIN_RANGE_RST;
      max_range_r <= MAX_RANGE_RST;
      cnt_r       <= '0;
      lowest_x_r  <= COORD_MAX;
      highest_x_r <= COORD_MIN;
      lowest_y_r  <= COORD_MAX;
      highest_y_r <= COORD_MIN;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr) begin
        unique case (paddr[2])
          REG_MIN_RANGE: min_range_r <= pwdata[RANGE_BITS-1:0];
          REG_MAX_RANGE: max_range_r <= pwdata[RANGE_BITS-1:0];
        endcase
      end

      // Result register occupancy
      if (emit_w) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end

      if (in_fire) begin
        busy_r <= 1'b1;
        step_r <= '0;
        if (in_data.scan_start) begin
          cnt_r <= '0;
        end
      end else if (busy_r) begin
        priority if (ucw.jmp_drop && drop_w) begin
          busy_r <= 1'b0;
          step_r <= '0;
        end else if (hold_w) begin
          step_r <= step_r;
        end else if (ucw.last) begin
          busy_r      <= 1'b0;
          step_r      <= '0;
          cnt_r       <= cnt_r + 1'b1;
          lowest_y_r  <= low_y_nxt;
          highest_y_r <= high_y_nxt;
        end else begin
          step_r <= step_r + 1'b1;
          if (ucw.fin == FN_GX) begin
            if (gsat_w < lowest_x_r) begin
              lowest_x_r <= gsat_w;
            end
            if (gsat_w > highest_x_r) begin
              highest_x_r <= gsat_w;
            end
          end
        end
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Held point lies inside the held box
  assign in_box_w = (out_r.box_min_x <= out_r.point_x) && (out_r.point_x <= out_r.box_max_x) &&
                    (out_r.box_min_y <= out_r.point_y) && (out_r.point_y <= out_r.box_max_y);

  // Checks
  `STGP_ASSERT(a_idle_step_zero, !busy_r, step_r == '0, "step counter not at zero while idle")
  `STGP_ASSERT(a_point_in_box, out_valid_r, in_box_w, "result point lies outside its bounding box")
  `STGP_ASSERT_NEXT(a_drop_frees, busy_r && !in_fire && ucw.jmp_drop && drop_w, !busy_r && (cnt_r == $past(cnt_r)), "rejected beam did not release the sequencer")
  `STGP_ASSERT_NEXT(a_emit_number, emit_w && !in_fire, out_valid_r && !busy_r && (out_r.point_number == $past(cnt_r)), "emitted transaction lost or misnumbered")

endmodule

`default_nettype wire
